@@ sv/triple_fifo_with_copy_core_macros.svh @@
// Assertion macros shared by the triple FIFO core.
`ifndef TRIPLE_FIFO_WITH_COPY_CORE_MACROS_SVH
`define TRIPLE_FIFO_WITH_COPY_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define TFC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tfc_pkg.sv @@
// Shared types and codes for the triple FIFO core.
`default_nettype none

package tfc_pkg;

   localparam int NUM_QUEUES = 3;

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;

   localparam logic [1:0] QUEUE_ONE   = 2'd0;
   localparam logic [1:0] QUEUE_TWO   = 2'd1;
   localparam logic [1:0] QUEUE_THREE = 2'd2;
   localparam logic [1:0] QUEUE_NONE  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               popped_valid;
      logic [1:0]         status;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ sv/tfc_entry_ram.sv @@
// Entry store: single write port, single registered read port.
`default_nettype none

module tfc_entry_ram #(
   parameter int DEPTH  = 48,
   parameter int ADDR_W = 6,
   parameter int WIDTH  = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/tfc_rsp_buffer.sv @@
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module tfc_rsp_buffer
   import tfc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output logic              full,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   rsp_item_type out_ff, out_in, skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic         take;

   assign take      = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff && !take;
      skid_valid_in = skid_valid_ff;
      if (take && skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!out_valid_in) begin
            out_in       = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ sv/triple_fifo_with_copy_core.sv @@
// Top level of the triple FIFO core with queue copy.
`default_nettype none
`include "triple_fifo_with_copy_core_macros.svh"

// Three FIFO queues of QUEUE_DEPTH entries share one entry RAM with a
// registered read port; head and fill levels sit in flops. A push, a pop
// from an empty queue and a copy that moves nothing finish in the cycle
// they are accepted. A pop reads the head entry into the RAM read register
// and gives its result from the ST_POP state. A copy of n entries does one
// RAM read per entry, pipelined into the write of the destination, and
// input is stalled while it runs. Every transaction gives one result; up
// to two results are held for the output side before input is stalled.
module triple_fifo_with_copy_core
   import tfc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic [1:0]         req_queue_sel,
   input  wire logic [1:0]         req_dest_sel,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_popped_value,
   output logic                    rsp_popped_valid,
   output logic [1:0]              rsp_status
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_POP  = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;

   function automatic logic [1:0] pick_queue(input logic [1:0] sel);
      return (sel == QUEUE_NONE) ? QUEUE_THREE : sel;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0]       q,
                                                   input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] off);
      logic [PTR_W:0]    sum;
      logic [PTR_W:0]    pos;
      logic [ADDR_W-1:0] base;
      sum = {1'b0, head} + {1'b0, off};
      pos = (sum >= (PTR_W+1)'(QUEUE_DEPTH)) ? sum - (PTR_W+1)'(QUEUE_DEPTH) : sum;
      if (q == QUEUE_ONE) begin
         base = '0;
      end else if (q == QUEUE_TWO) begin
         base = ADDR_W'(QUEUE_DEPTH);
      end else begin
         base = ADDR_W'(2 * QUEUE_DEPTH);
      end
      return base + ADDR_W'(pos[PTR_W-1:0]);
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] head_ff [NUM_QUEUES];
   logic [PTR_W-1:0] head_in [NUM_QUEUES];
   logic [CNT_W-1:0] fill_ff [NUM_QUEUES];
   logic [CNT_W-1:0] fill_in [NUM_QUEUES];

   logic [1:0]       copy_src_ff, copy_src_in, copy_dst_ff, copy_dst_in;
   logic [PTR_W-1:0] copy_head_ff, copy_head_in;
   logic [CNT_W-1:0] copy_n_ff, copy_n_in;
   logic [CNT_W-1:0] copy_rd_idx_ff, copy_rd_idx_in;
   logic [PTR_W-1:0] copy_wr_idx_ff, copy_wr_idx_in;
   logic             copy_wr_valid_ff, copy_wr_valid_in;

   logic                  req_accept;
   logic [1:0]            src;
   logic [PTR_W-1:0]      src_head;
   logic [CNT_W-1:0]      src_fill;
   logic                  copy_active;

   logic                  ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data, ram_rd_data;

   logic                  res_push, buf_full;
   rsp_item_type          res_item, out_item;

   assign req_stall   = (state_ff != ST_IDLE) || buf_full;
   assign req_accept  = req_valid && !req_stall;
   assign src         = pick_queue(req_queue_sel);
   assign src_head    = head_ff[src];
   assign src_fill    = fill_ff[src];
   assign copy_active = (req_dest_sel != QUEUE_NONE) && (req_dest_sel != src);

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      fill_in          = fill_ff;
      copy_src_in      = copy_src_ff;
      copy_dst_in      = copy_dst_ff;
      copy_head_in     = copy_head_ff;
      copy_n_in        = copy_n_ff;
      copy_rd_idx_in   = copy_rd_idx_ff;
      copy_wr_idx_in   = copy_wr_idx_ff;
      copy_wr_valid_in = copy_wr_valid_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = '0;
      ram_wr_data      = '0;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = '0;
      res_push         = 1'b0;
      res_item         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == FUNC_PUSH) begin
                  res_push = 1'b1;
                  if (src_fill >= CNT_W'(QUEUE_DEPTH)) begin
                     res_item.status = STATUS_FULL;
                  end else begin
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = slot_addr(src, src_head, src_fill[PTR_W-1:0]);
                     ram_wr_data  = DATA_WIDTH'($unsigned(req_value));
                     fill_in[src] = src_fill + CNT_W'(1);
                  end
               end else if (req_func == FUNC_POP) begin
                  if (src_fill == '0) begin
                     res_push        = 1'b1;
                     res_item.status = STATUS_EMPTY;
                  end else begin
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = slot_addr(src, src_head, '0);
                     head_in[src] = (src_head == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : src_head + PTR_W'(1);
                     fill_in[src] = src_fill - CNT_W'(1);
                     state_in     = ST_POP;
                  end
               end else begin
                  res_push = 1'b1;
                  if (copy_active) begin
                     head_in[req_dest_sel] = '0;
                     fill_in[req_dest_sel] = src_fill;
                     copy_src_in           = src;
                     copy_dst_in           = req_dest_sel;
                     copy_head_in          = src_head;
                     copy_n_in             = src_fill;
                     copy_rd_idx_in        = '0;
                     copy_wr_valid_in      = 1'b0;
                     if (src_fill != '0) begin
                        state_in = ST_COPY;
                     end
                  end
               end
            end
         end
         ST_POP: begin
            res_push              = 1'b1;
            res_item.popped_value = 32'($signed(ram_rd_data));
            res_item.popped_valid = 1'b1;
            res_item.status       = STATUS_OK;
            state_in              = ST_IDLE;
         end
         ST_COPY: begin
            copy_wr_valid_in = (copy_rd_idx_ff != copy_n_ff);
            copy_wr_idx_in   = copy_rd_idx_ff[PTR_W-1:0];
            if (copy_rd_idx_ff != copy_n_ff) begin
               ram_rd_en      = 1'b1;
               ram_rd_addr    = slot_addr(copy_src_ff, copy_head_ff,
                                          copy_rd_idx_ff[PTR_W-1:0]);
               copy_rd_idx_in = copy_rd_idx_ff + CNT_W'(1);
            end
            if (copy_wr_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot_addr(copy_dst_ff, '0, copy_wr_idx_ff);
               ram_wr_data = ram_rd_data;
            end
            if ((copy_rd_idx_ff == copy_n_ff) && copy_wr_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         copy_wr_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         copy_wr_valid_ff <= copy_wr_valid_in;
         head_ff          <= head_in;
         fill_ff          <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_src_ff    <= copy_src_in;
      copy_dst_ff    <= copy_dst_in;
      copy_head_ff   <= copy_head_in;
      copy_n_ff      <= copy_n_in;
      copy_rd_idx_ff <= copy_rd_idx_in;
      copy_wr_idx_ff <= copy_wr_idx_in;
   end

   tfc_entry_ram #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W),
      .WIDTH  (DATA_WIDTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tfc_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_item (res_item),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (out_item)
   );

   assign rsp_popped_value = out_item.popped_value;
   assign rsp_popped_valid = out_item.popped_valid;
   assign rsp_status       = out_item.status;

   `TFC_ASSERT_ALWAYS(a_fill_bound, clock, reset,
      (fill_ff[0] <= CNT_W'(QUEUE_DEPTH)) && (fill_ff[1] <= CNT_W'(QUEUE_DEPTH)) &&
      (fill_ff[2] <= CNT_W'(QUEUE_DEPTH)), "queue fill level beyond depth")
   `TFC_ASSERT_ALWAYS(a_no_overflow, clock, reset, !(res_push && buf_full),
      "result written into a full buffer")
   `TFC_ASSERT_NEXT(a_pop_result, clock, reset,
      req_accept && (req_func == FUNC_POP) && (src_fill != '0),
      res_push && res_item.popped_valid, "pop of a filled queue gave no entry")
   `TFC_ASSERT_ALWAYS(a_copy_range, clock, reset,
      !((state_ff == ST_COPY) && copy_wr_valid_ff) ||
      (CNT_W'(copy_wr_idx_ff) < copy_n_ff), "copy write beyond source fill")

endmodule

`default_nettype wire
